// ===== sv/twcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcw_pkg
// Shared types and constants for the two-color wave pixel generator.
// ----------------------------------------------------------------------------
package twcw_pkg;

  localparam int NUM_LEDS_DEF = 256;

  // Opcodes
  localparam logic [1:0] OP_RESTART = 2'd0;
  localparam logic [1:0] OP_ADVANCE = 2'd1;
  localparam logic [1:0] OP_RENDER  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_COLOR_A    = 2'd0;
  localparam logic [1:0] CFG_COLOR_B    = 2'd1;
  localparam logic [1:0] CFG_STEP_DELAY = 2'd2;
  localparam logic [1:0] CFG_BAND_LEN   = 2'd3;

  localparam logic [23:0] COLOR_A_RST    = 24'hFF0000;
  localparam logic [23:0] COLOR_B_RST    = 24'h0000FF;
  localparam logic [15:0] STEP_DELAY_RST = 16'd100;
  localparam logic [15:0] BAND_LEN_RST   = 16'd8;

  // Step counter
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] DIV_STEPS_M1   = 6'd32;
  localparam logic [CNT_W-1:0] BLEND_STEPS_M1 = 6'd7;

  typedef struct packed {
    logic time_clear;
    logic time_add;
    logic div_load_time;
    logic div_load_pos;
    logic div_step;
    logic sel_load;
    logic mul_load;
    logic blend_step;
    logic out_load;
  } twcw_cmd_t;

endpackage

// ===== sv/twcw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcw_ctrl
// Sequencer: accepts transactions, steps the datapath through the time
// division, the position modulo, color select, multiply and blend division,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module twcw_ctrl
  import twcw_pkg::*;
#(
  parameter int NUM_LEDS = NUM_LEDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_led_index,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  output twcw_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIVT  = 3'd1;
  localparam logic [2:0] S_POS   = 3'd2;
  localparam logic [2:0] S_DIVP  = 3'd3;
  localparam logic [2:0] S_SEL   = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_BLEND = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_range;

  assign in_range  = ({24'd0, in_led_index} < 32'(NUM_LEDS));
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            OP_RESTART: cmd.time_clear = 1'b1;
            OP_ADVANCE: cmd.time_add = 1'b1;
            OP_RENDER: begin
              if (in_range) begin
                cmd.div_load_time = 1'b1;
                cnt_nxt           = DIV_STEPS_M1;
                state_nxt         = S_DIVT;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIVT: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) state_nxt = S_POS;
        else cnt_nxt = cnt_r - 1'b1;
      end
      S_POS: begin
        cmd.div_load_pos = 1'b1;
        cnt_nxt          = DIV_STEPS_M1;
        state_nxt        = S_DIVP;
      end
      S_DIVP: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) state_nxt = S_SEL;
        else cnt_nxt = cnt_r - 1'b1;
      end
      S_SEL: begin
        cmd.sel_load = 1'b1;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        cnt_nxt      = BLEND_STEPS_M1;
        state_nxt    = S_BLEND;
      end
      S_BLEND: begin
        cmd.blend_step = 1'b1;
        if (cnt_r == '0) state_nxt = S_OUT;
        else cnt_nxt = cnt_r - 1'b1;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/twcw_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcw_dp
// Datapath: configuration registers, running time, shared serial divider,
// color select, channel multipliers, three blend dividers, result registers.
// ----------------------------------------------------------------------------
module twcw_dp
  import twcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic [15:0] in_elapsed_ms,
  input  logic [7:0]  in_led_index,
  input  twcw_cmd_t   cmd,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_pixel_index
);

  logic [23:0] color_a_r, color_b_r;
  logic [15:0] step_delay_r, band_len_r;
  logic [31:0] time_r;

  logic [15:0] delay_eff, len_eff;

  // shared restoring divider
  logic [32:0] quo_r;
  logic [16:0] rem_r;
  logic [16:0] dvsr_r;
  logic [17:0] rem_sh, rem_diff;
  logic        div_ge;

  logic [7:0]  idx_r;
  logic [15:0] phase_r;
  logic [23:0] cur_r, nxt_r;

  logic [17:0] rem_p1;
  logic        cur_a, nxt_a;
  logic [15:0] w1;

  logic [23:0] num_r [3];
  logic [7:0]  q_r [3];
  logic [23:0] bdiv_r;
  logic [23:0] prod_sum [3];
  logic        bge [3];

  assign delay_eff = (step_delay_r == 16'd0) ? 16'd1 : step_delay_r;
  assign len_eff   = (band_len_r == 16'd0) ? 16'd1 : band_len_r;

  assign rem_sh   = {rem_r, quo_r[32]};
  assign rem_diff = rem_sh - {1'b0, dvsr_r};
  assign div_ge   = (rem_sh >= {1'b0, dvsr_r});

  assign rem_p1 = {1'b0, rem_r} + 18'd1;
  assign cur_a  = (rem_r < {1'b0, len_eff});
  assign nxt_a  = (rem_p1 < {2'b0, len_eff}) || (rem_p1 == {1'b0, dvsr_r});
  assign w1     = delay_eff - phase_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_sum[k] = 24'(w1 * cur_r[8*k +: 8]) + 24'(phase_r * nxt_r[8*k +: 8]);
      bge[k]      = (num_r[k] >= bdiv_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_a_r    <= COLOR_A_RST;
      color_b_r    <= COLOR_B_RST;
      step_delay_r <= STEP_DELAY_RST;
      band_len_r   <= BAND_LEN_RST;
      time_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_COLOR_A:    color_a_r <= cfg_wdata;
          CFG_COLOR_B:    color_b_r <= cfg_wdata;
          CFG_STEP_DELAY: step_delay_r <= cfg_wdata[15:0];
          CFG_BAND_LEN:   band_len_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (cmd.time_clear) time_r <= '0;
      else if (cmd.time_add) time_r <= time_r + {16'd0, in_elapsed_ms};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load_time) begin
      idx_r  <= in_led_index;
      quo_r  <= {1'b0, time_r};
      rem_r  <= '0;
      dvsr_r <= {1'b0, delay_eff};
    end else if (cmd.div_load_pos) begin
      phase_r <= rem_r[15:0];
      quo_r   <= {1'b0, quo_r[31:0]} + {25'd0, idx_r};
      rem_r   <= '0;
      dvsr_r  <= {len_eff, 1'b0};
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[31:0], div_ge};
      rem_r <= div_ge ? rem_diff[16:0] : rem_sh[16:0];
    end

    if (cmd.sel_load) begin
      cur_r <= cur_a ? color_a_r : color_b_r;
      nxt_r <= nxt_a ? color_a_r : color_b_r;
    end

    if (cmd.mul_load) begin
      for (int k = 0; k < 3; k++) num_r[k] <= prod_sum[k];
      bdiv_r <= {1'b0, delay_eff, 7'd0};
    end else if (cmd.blend_step) begin
      for (int k = 0; k < 3; k++) begin
        if (bge[k]) num_r[k] <= num_r[k] - bdiv_r;
        q_r[k] <= {q_r[k][6:0], bge[k]};
      end
      bdiv_r <= {1'b0, bdiv_r[23:1]};
    end

    if (cmd.out_load) begin
      out_red         <= q_r[2];
      out_green       <= q_r[1];
      out_blue        <= q_r[0];
      out_pixel_index <= idx_r;
    end
  end

endmodule

// ===== sv/two_color_wave_pixel_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_color_wave_pixel_generator
// Moving two-color LED wave: running time, step/phase split, band select,
// linear blend of the two colors per LED.
// ----------------------------------------------------------------------------
//  channel  handshake           payload
//  in       in_valid/in_ready   in_opcode, in_elapsed_ms, in_led_index
//  out      out_valid/out_ready out_red, out_green, out_blue, out_pixel_index
//  cfg      cfg_we              cfg_index, cfg_wdata
//
//  Restart and advance update the running time and stay idle. A render runs
//  a 33-step time divide, a 33-step position modulo on one shared serial
//  divider, select, multiply, an 8-step blend divide and the output load,
//  then in_ready returns. A finished result waits in the output register;
//  the next transaction is taken meanwhile and stalls only at its own load.
//  Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module two_color_wave_pixel_generator
  import twcw_pkg::*;
#(
  parameter int NUM_LEDS = NUM_LEDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_elapsed_ms,
  input  logic [7:0]  in_led_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_pixel_index
);

  twcw_cmd_t cmd;

  twcw_ctrl #(
    .NUM_LEDS(NUM_LEDS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_opcode   (in_opcode),
    .in_led_index(in_led_index),
    .in_ready    (in_ready),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .cmd         (cmd)
  );

  twcw_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_elapsed_ms  (in_elapsed_ms),
    .in_led_index   (in_led_index),
    .cmd            (cmd),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_pixel_index(out_pixel_index)
  );

  // result register is never overwritten while a result is pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  // datapath commands are mutually exclusive
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.div_load_time, cmd.div_load_pos, cmd.div_step, cmd.sel_load,
              cmd.mul_load, cmd.blend_step, cmd.out_load}))
    else $error("conflicting datapath commands");

  // restart and advance complete in the accept cycle
  a_time_op_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_opcode == OP_RESTART || in_opcode == OP_ADVANCE))
    |=> in_ready)
    else $error("time update did not return to idle");

  // a result appears only from an output load
  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result valid without load");

endmodule
